>>> rtl/nsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int FNUM_W     = 6;
    localparam int CPOS_W     = 7;
    localparam int TYPE_W     = 40;
    localparam int TLEN_W     = 3;
    localparam int ADDR_CHARS = 5;

    localparam int MAX_FIELD_LEN_DEF = 64;
    localparam int MAX_FIELDS_DEF    = 32;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h46;

    typedef enum logic [2:0] {
        PS_WAIT,
        PS_START,
        PS_ADDR,
        PS_FIELD,
        PS_CSUM,
        PS_DISCARD
    } parse_state_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR,
        KIND_END,
        KIND_OK,
        KIND_BAD,
        KIND_ABORT
    } kind_t;

endpackage

`default_nettype wire

>>> rtl/nsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nsp_rx_if;
    import nsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsp_res_if;
    import nsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [FNUM_W-1:0] field_number;
    logic [CPOS_W-1:0] char_position;
    logic [TYPE_W-1:0] sentence_type;
    logic [BYTE_W-1:0] received_checksum;
    logic [BYTE_W-1:0] computed_checksum;

    modport source (
        output valid, output kind, output data_byte, output field_number,
        output char_position, output sentence_type, output received_checksum,
        output computed_checksum, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input field_number,
        input char_position, input sentence_type, input received_checksum,
        input computed_checksum, output ready
    );
endinterface

`default_nettype wire

>>> rtl/nmea_sentence_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted byte is held in the input register; its request, if any, is then written
// to the result register. Throughput: one byte per cycle unless a request stalls; the
// parser state sits in a single registered pass between the input and result registers.
// rx.ready drops only while a byte that yields a request waits on a full result register.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to
// waiting for '$' with all counters and checksums cleared.
module nmea_sentence_parser #(
    parameter int MAX_FIELD_LEN = nsp_pkg::MAX_FIELD_LEN_DEF,
    parameter int MAX_FIELDS    = nsp_pkg::MAX_FIELDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nsp_rx_if.sink     rx,
    nsp_res_if.source  res
);
    import nsp_pkg::*;

    localparam int FLEN_W = $clog2(MAX_FIELD_LEN + 2);
    localparam int FCNT_W = $clog2(MAX_FIELDS + 2);
    localparam logic [FLEN_W-1:0] FLEN_MAX = FLEN_W'(MAX_FIELD_LEN);
    localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FIELDS);
    localparam logic [TLEN_W-1:0] TLEN_FULL = TLEN_W'(ADDR_CHARS);

    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    parse_state_t      state_reg,   state_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [BYTE_W-1:0] hex_reg,     hex_next;
    logic              too_big_reg, too_big_next;
    logic [TYPE_W-1:0] type_reg,    type_next;
    logic [TLEN_W-1:0] tlen_reg,    tlen_next;
    logic [FLEN_W-1:0] flen_reg,    flen_next;
    logic [FCNT_W-1:0] fcnt_reg,    fcnt_next;

    logic              res_valid_reg;
    kind_t             kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [FNUM_W-1:0] fnum_reg;
    logic [CPOS_W-1:0] cpos_reg;
    logic [TYPE_W-1:0] stype_reg;
    logic [BYTE_W-1:0] rsum_reg;
    logic [BYTE_W-1:0] csum_reg;

    logic              emit;
    kind_t             kind_o;
    logic [BYTE_W-1:0] data_o;
    logic [FNUM_W-1:0] fnum_o;
    logic [CPOS_W-1:0] cpos_o;
    logic [BYTE_W-1:0] rsum_o;
    logic [BYTE_W-1:0] csum_o;

    logic              eol;
    logic              is_dec;
    logic              is_hex_alpha;
    logic [3:0]        digit;
    logic              out_free;
    logic              advance;
    logic [31:0]       fcnt_ext;
    logic [31:0]       fcnt_inc_ext;
    logic [31:0]       flen_ext;
    logic [31:0]       flen_cur_ext;

    assign eol          = (byte_reg == CH_CR) || (byte_reg == CH_LF);
    assign is_dec       = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign is_hex_alpha = (byte_reg >= CH_A) && (byte_reg <= CH_F);
    assign digit        = is_dec ? byte_reg[3:0] : 4'(byte_reg[3:0] + 4'd9);

    assign out_free = !res_valid_reg || res.ready;
    assign advance  = byte_valid_reg && (!emit || out_free);
    assign rx.ready = !byte_valid_reg || advance;

    assign fcnt_ext     = 32'(fcnt_next);
    assign fcnt_inc_ext = 32'(fcnt_reg) + 32'd1;
    assign flen_ext     = 32'(flen_next);
    assign flen_cur_ext = 32'(flen_reg);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        xor_next     = xor_reg;
        hex_next     = hex_reg;
        too_big_next = too_big_reg;
        type_next    = type_reg;
        tlen_next    = tlen_reg;
        flen_next    = flen_reg;
        fcnt_next    = fcnt_reg;
        unique case (state_reg)
            PS_WAIT:
            begin
                if (byte_reg == CH_DOLLAR)
                begin
                    xor_next     = '0;
                    hex_next     = '0;
                    too_big_next = 1'b0;
                    type_next    = '0;
                    tlen_next    = '0;
                    flen_next    = '0;
                    fcnt_next    = '0;
                    state_next   = PS_START;
                end
                else if (!eol)
                begin
                    state_next = PS_DISCARD;
                end
            end
            PS_START:
            begin
                if (eol)
                begin
                    state_next = PS_DISCARD;
                end
                else
                begin
                    xor_next   = xor_reg ^ byte_reg;
                    type_next  = {type_reg[TYPE_W-BYTE_W-1:0], byte_reg};
                    tlen_next  = TLEN_W'(1);
                    state_next = PS_ADDR;
                end
            end
            PS_ADDR:
            begin
                if (eol)
                begin
                    state_next = PS_DISCARD;
                end
                else
                begin
                    xor_next = xor_reg ^ byte_reg;
                    if (byte_reg == CH_COMMA)
                    begin
                        state_next = (tlen_reg == TLEN_FULL) ? PS_FIELD : PS_DISCARD;
                    end
                    else if (tlen_reg >= TLEN_FULL)
                    begin
                        tlen_next  = TLEN_W'(ADDR_CHARS + 1);
                        state_next = PS_DISCARD;
                    end
                    else
                    begin
                        type_next = {type_reg[TYPE_W-BYTE_W-1:0], byte_reg};
                        tlen_next = TLEN_W'(tlen_reg + TLEN_W'(1));
                    end
                end
            end
            PS_FIELD:
            begin
                if (eol)
                begin
                    state_next = PS_DISCARD;
                end
                else if ((byte_reg == CH_COMMA) || (byte_reg == CH_STAR))
                begin
                    if (byte_reg == CH_COMMA)
                    begin
                        xor_next = xor_reg ^ byte_reg;
                    end
                    else
                    begin
                        hex_next     = '0;
                        too_big_next = 1'b0;
                        state_next   = PS_CSUM;
                    end
                    fcnt_next = FCNT_W'(fcnt_reg + FCNT_W'(1));
                    if (fcnt_next > FCNT_MAX)
                    begin
                        state_next = PS_DISCARD;
                    end
                    else
                    begin
                        flen_next = '0;
                    end
                end
                else
                begin
                    xor_next = xor_reg ^ byte_reg;
                    if (flen_reg >= FLEN_MAX)
                    begin
                        flen_next  = FLEN_W'(MAX_FIELD_LEN + 1);
                        state_next = PS_DISCARD;
                    end
                    else
                    begin
                        flen_next = FLEN_W'(flen_reg + FLEN_W'(1));
                    end
                end
            end
            PS_CSUM:
            begin
                if (is_dec || is_hex_alpha)
                begin
                    too_big_next = too_big_reg || (hex_reg > 8'h0F);
                    hex_next     = {hex_reg[3:0], digit};
                end
                else if (eol)
                begin
                    state_next = PS_WAIT;
                end
                else
                begin
                    state_next = PS_DISCARD;
                end
            end
            PS_DISCARD:
            begin
                state_next = eol ? PS_WAIT : PS_DISCARD;
            end
            default:
            begin
                state_next = PS_WAIT;
            end
        endcase
    end

    // request fields
    always_comb
    begin
        emit   = 1'b0;
        kind_o = KIND_ABORT;
        data_o = '0;
        fnum_o = fcnt_ext[FNUM_W-1:0];
        cpos_o = flen_ext[CPOS_W-1:0];
        unique case (state_reg)
            PS_START:
            begin
                emit = eol;
            end
            PS_ADDR:
            begin
                if (eol)
                begin
                    emit = 1'b1;
                end
                else if (byte_reg == CH_COMMA)
                begin
                    emit = (tlen_reg != TLEN_FULL);
                end
                else
                begin
                    emit = (tlen_reg >= TLEN_FULL);
                end
            end
            PS_FIELD:
            begin
                emit = 1'b1;
                if (eol)
                begin
                    kind_o = KIND_ABORT;
                end
                else if ((byte_reg == CH_COMMA) || (byte_reg == CH_STAR))
                begin
                    if (fcnt_next <= FCNT_MAX)
                    begin
                        kind_o = KIND_END;
                        cpos_o = flen_cur_ext[CPOS_W-1:0];
                    end
                end
                else if (flen_reg < FLEN_MAX)
                begin
                    kind_o = KIND_CHAR;
                    data_o = byte_reg;
                    fnum_o = fcnt_inc_ext[FNUM_W-1:0];
                end
            end
            PS_CSUM:
            begin
                if (!(is_dec || is_hex_alpha))
                begin
                    emit = 1'b1;
                    if (eol || (byte_reg == CH_COMMA))
                    begin
                        kind_o = (!too_big_reg && (hex_reg == xor_reg)) ? KIND_OK : KIND_BAD;
                        cpos_o = '0;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if ((kind_o == KIND_CHAR) || (kind_o == KIND_END))
        begin
            rsum_o = '0;
            csum_o = '0;
        end
        else
        begin
            rsum_o = hex_next;
            csum_o = xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= PS_WAIT;
            xor_reg        <= '0;
            hex_reg        <= '0;
            too_big_reg    <= 1'b0;
            type_reg       <= '0;
            tlen_reg       <= '0;
            flen_reg       <= '0;
            fcnt_reg       <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                byte_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                state_reg   <= state_next;
                xor_reg     <= xor_next;
                hex_reg     <= hex_next;
                too_big_reg <= too_big_next;
                type_reg    <= type_next;
                tlen_reg    <= tlen_next;
                flen_reg    <= flen_next;
                fcnt_reg    <= fcnt_next;
            end
            if (advance && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            kind_reg  <= kind_o;
            data_reg  <= data_o;
            fnum_reg  <= fnum_o;
            cpos_reg  <= cpos_o;
            stype_reg <= type_next;
            rsum_reg  <= rsum_o;
            csum_reg  <= csum_o;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.kind              = kind_reg;
    assign res.data_byte         = data_reg;
    assign res.field_number      = fnum_reg;
    assign res.char_position     = cpos_reg;
    assign res.sentence_type     = stype_reg;
    assign res.received_checksum = rsum_reg;
    assign res.computed_checksum = csum_reg;

endmodule

`default_nettype wire

>>> rtl/nsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nsp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    input  logic                        rx_ready,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic [nsp_pkg::KIND_W-1:0]  kind,
    input  logic [nsp_pkg::BYTE_W-1:0]  data_byte,
    input  logic [nsp_pkg::FNUM_W-1:0]  field_number,
    input  logic [nsp_pkg::CPOS_W-1:0]  char_position,
    input  logic [nsp_pkg::TYPE_W-1:0]  sentence_type,
    input  logic [nsp_pkg::BYTE_W-1:0]  received_checksum,
    input  logic [nsp_pkg::BYTE_W-1:0]  computed_checksum
);
    import nsp_pkg::*;

    // stalled request holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable({kind, data_byte, field_number,
            char_position, sentence_type, received_checksum, computed_checksum}))
        else $error("result request changed while stalled");

    // a new request follows an accepted byte through the input and result registers
    a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("result request without an accepted byte");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind != KIND_CHAR) |-> (data_byte == '0))
        else $error("data byte set on a non-character request");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_OK) |-> (received_checksum == computed_checksum)
            && (char_position == '0))
        else $error("sentence ok with differing checksums");

endmodule

bind nmea_sentence_parser nsp_checker u_nsp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_valid          (rx.valid),
    .rx_ready          (rx.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .kind              (res.kind),
    .data_byte         (res.data_byte),
    .field_number      (res.field_number),
    .char_position     (res.char_position),
    .sentence_type     (res.sentence_type),
    .received_checksum (res.received_checksum),
    .computed_checksum (res.computed_checksum)
);

`default_nettype wire
